// File: design/ccf_pkg.sv
// Shared types, codes and constants of the collector connection manager.
// No dependencies; imported by ccf_step, collector_connection_fsm and the testbench.
`default_nettype none

package ccf_pkg;

  localparam int EP_BITS     = 48;
  localparam int BACKOFF_CAP = 6;

  localparam logic [47:0] EP_MASK =
    (EP_BITS >= 48) ? 48'hFFFF_FFFF_FFFF : 48'((64'd1 << EP_BITS) - 64'd1);

  localparam logic [31:0] MS_PER_SECOND = 32'd1000;
  localparam logic [7:0]  ATTEMPT_MAX   = 8'd255;

  localparam logic [31:0] DEFAULT_IDLE_HOLD_RESET = 32'd5000;
  localparam logic [15:0] MAX_CONNECT_RESET       = 16'd30;

  localparam logic REG_DEFAULT_IDLE_HOLD = 1'b0;
  localparam logic REG_MAX_CONNECT       = 1'b1;

  localparam logic [3:0] ACT_START      = 4'd0;
  localparam logic [3:0] ACT_STOP       = 4'd1;
  localparam logic [3:0] ACT_CANDIDATES = 4'd2;
  localparam logic [3:0] ACT_IDLE_EXP   = 4'd3;
  localparam logic [3:0] ACT_CONN_EXP   = 4'd4;
  localparam logic [3:0] ACT_CONNECTED  = 4'd5;
  localparam logic [3:0] ACT_CONN_FAIL  = 4'd6;
  localparam logic [3:0] ACT_CLOSE      = 4'd7;
  localparam logic [3:0] ACT_RECV       = 4'd8;
  localparam logic [3:0] ACT_SEND       = 4'd9;
  localparam logic [3:0] ACT_DELETE     = 4'd10;
  localparam logic [3:0] ACT_IGNORED    = 4'd15;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISC = 3'd1;
  localparam logic [2:0] ST_CONN = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_EST  = 3'd4;

  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_START  = 2'd1;
  localparam logic [1:0] TMR_CANCEL = 2'd2;

  localparam logic [2:0] SESS_NONE     = 3'd0;
  localparam logic [2:0] SESS_OPEN     = 3'd1;
  localparam logic [2:0] SESS_RELEASE  = 3'd2;
  localparam logic [2:0] SESS_REL_OPEN = 3'd3;
  localparam logic [2:0] SESS_INIT     = 3'd4;
  localparam logic [2:0] SESS_DELETE   = 3'd5;

  localparam logic [1:0] SEND_NONE      = 2'd0;
  localparam logic [1:0] SEND_FORWARDED = 2'd1;
  localparam logic [1:0] SEND_DROPPED   = 2'd2;

  localparam logic [1:0] LINK_UNCHANGED = 2'd0;
  localparam logic [1:0] LINK_INIT      = 2'd1;
  localparam logic [1:0] LINK_DOWN      = 2'd2;
  localparam logic [1:0] LINK_UP        = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [47:0] active_endpoint;
    logic [47:0] backup_endpoint;
    logic        recv_ok;
    logic        control_hint;
    logic        send_is_uve;
  } ccf_item_t;

  typedef struct packed {
    logic [2:0]  fsm_state;
    logic [47:0] active_server;
    logic [47:0] backup_server;
    logic [47:0] current_server;
    logic [7:0]  attempt_count;
    logic [31:0] idle_hold_ms;
    logic        connect_armed;
    logic        idle_armed;
  } ccf_state_t;

  typedef struct packed {
    logic [2:0]  fsm_state_out;
    logic [47:0] server_out;
    logic [1:0]  connect_timer_cmd;
    logic [15:0] connect_seconds;
    logic [1:0]  idle_timer_cmd;
    logic [31:0] idle_hold_out;
    logic [2:0]  session_cmd;
    logic [1:0]  send_result;
    logic [1:0]  link_status;
    logic        consumed;
  } ccf_result_t;

endpackage

`default_nettype wire

// File: design/collector_connection_fsm.sv
// An accepted word waits in the input register, then its result word is held in the result
// register. One word per cycle unless the result register stalls; the connection state is
// updated as a word moves on into the result register, so each word sees the previous one's
// state. A stalled result register holds the input register; one word may wait in each.
// Reset (rst, synchronous, active high) returns the machine to idle with no servers,
// zero attempts and hold time, timers disarmed, both registers empty, config at defaults.
`default_nettype none

module collector_connection_fsm import ccf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  action,
  input  wire logic [47:0] active_endpoint,
  input  wire logic [47:0] backup_endpoint,
  input  wire logic        recv_ok,
  input  wire logic        control_hint,
  input  wire logic        send_is_uve,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       fsm_state_out,
  output logic [47:0]      server_out,
  output logic [1:0]       connect_timer_cmd,
  output logic [15:0]      connect_seconds,
  output logic [1:0]       idle_timer_cmd,
  output logic [31:0]      idle_hold_out,
  output logic [2:0]       session_cmd,
  output logic [1:0]       send_result,
  output logic [1:0]       link_status,
  output logic             consumed
);

  logic [31:0] default_idle_hold_ms;
  logic [15:0] max_connect_seconds;
  ccf_state_t  state;
  ccf_state_t  state_next;
  ccf_item_t   in_item;
  logic        in_full;
  ccf_result_t result;
  ccf_result_t result_next;
  logic        advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  ccf_step u_step (
    .item                 (in_item),
    .cur                  (state),
    .default_idle_hold_ms (default_idle_hold_ms),
    .max_connect_seconds  (max_connect_seconds),
    .nxt                  (state_next),
    .res                  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_idle_hold_ms <= DEFAULT_IDLE_HOLD_RESET;
      max_connect_seconds  <= MAX_CONNECT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEFAULT_IDLE_HOLD) begin
        default_idle_hold_ms <= cfg_data;
      end else begin
        max_connect_seconds <= cfg_data[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.action          <= action;
      in_item.active_endpoint <= active_endpoint;
      in_item.backup_endpoint <= backup_endpoint;
      in_item.recv_ok         <= recv_ok;
      in_item.control_hint    <= control_hint;
      in_item.send_is_uve     <= send_is_uve;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign fsm_state_out     = result.fsm_state_out;
  assign server_out        = result.server_out;
  assign connect_timer_cmd = result.connect_timer_cmd;
  assign connect_seconds   = result.connect_seconds;
  assign idle_timer_cmd    = result.idle_timer_cmd;
  assign idle_hold_out     = result.idle_hold_out;
  assign session_cmd       = result.session_cmd;
  assign send_result       = result.send_result;
  assign link_status       = result.link_status;
  assign consumed          = result.consumed;

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("Advanced word did not reach the result register.");

  a_idle_armed_in_idle: assert property (@(posedge clk) disable iff (rst)
    state.idle_armed |-> state.fsm_state == ST_IDLE)
    else $error("Idle hold timer armed outside the idle state.");

  a_conn_armed_state: assert property (@(posedge clk) disable iff (rst)
    state.connect_armed |-> (state.fsm_state == ST_CONN || state.fsm_state == ST_INIT))
    else $error("Connect timer armed outside connect or client-init.");

  a_est_no_attempts: assert property (@(posedge clk) disable iff (rst)
    state.fsm_state == ST_EST |-> state.attempt_count == 8'd0)
    else $error("Attempt count not cleared in the established state.");

  a_unused_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !consumed) |->
      (connect_timer_cmd == TMR_NONE && session_cmd == SESS_NONE &&
       link_status == LINK_UNCHANGED && idle_timer_cmd == TMR_NONE))
    else $error("Discarded event issued a command.");

endmodule

`default_nettype wire

// File: design/ccf_step.sv
// Next-state and command logic for one event of the connection manager.
// Depends on ccf_pkg for the item, state and result types and all codes.
`default_nettype none

module ccf_step import ccf_pkg::*; (
  input  wire ccf_item_t   item,
  input  wire ccf_state_t  cur,
  input  wire logic [31:0] default_idle_hold_ms,
  input  wire logic [15:0] max_connect_seconds,
  output ccf_state_t       nxt,
  output ccf_result_t      res
);

  function automatic logic [15:0] conn_time(input logic [7:0] att, input logic [15:0] maxs);
    logic [7:0]  b;
    logic [15:0] t;
    b = (att < 8'(BACKOFF_CAP)) ? att : 8'(BACKOFF_CAP);
    t = (b == 8'd0) ? 16'd0 : 16'(32'd1 << (b - 8'd1));
    return (t < maxs) ? t : maxs;
  endfunction

  function automatic void conn_start(inout ccf_state_t s, inout ccf_result_t r,
                                     input logic [15:0] secs);
    r.connect_timer_cmd = TMR_START;
    r.connect_seconds   = secs;
    s.connect_armed     = 1'b1;
  endfunction

  function automatic void conn_cancel(inout ccf_state_t s, inout ccf_result_t r);
    r.connect_timer_cmd = TMR_CANCEL;
    r.connect_seconds   = 16'd0;
    s.connect_armed     = 1'b0;
  endfunction

  function automatic void idle_cancel(inout ccf_state_t s, inout ccf_result_t r);
    r.idle_timer_cmd = TMR_CANCEL;
    r.idle_hold_out  = 32'd0;
    s.idle_armed     = 1'b0;
  endfunction

  function automatic void release_all(inout ccf_state_t s, inout ccf_result_t r,
                                      input logic [31:0] dflt);
    if (s.idle_hold_ms == 32'd0) begin
      s.idle_hold_ms = dflt;
    end
    idle_cancel(s, r);
    r.session_cmd = SESS_RELEASE;
  endfunction

  function automatic void go_idle_hold(inout ccf_state_t s, inout ccf_result_t r,
                                       input logic [31:0] dflt);
    r.link_status = LINK_DOWN;
    release_all(s, r, dflt);
    if (s.idle_hold_ms != 32'd0) begin
      r.idle_timer_cmd = TMR_START;
      r.idle_hold_out  = s.idle_hold_ms;
      s.idle_armed     = 1'b1;
    end
    s.fsm_state = ST_IDLE;
  endfunction

  function automatic void enter_connect(inout ccf_state_t s, inout ccf_result_t r,
                                        input logic [15:0] maxs);
    r.session_cmd = (r.session_cmd == SESS_RELEASE) ? SESS_REL_OPEN : SESS_OPEN;
    if (s.attempt_count < ATTEMPT_MAX) begin
      s.attempt_count = s.attempt_count + 8'd1;
    end
    conn_start(s, r, conn_time(s.attempt_count, maxs));
    s.fsm_state = ST_CONN;
  endfunction

  function automatic void swap_to_backup(inout ccf_state_t s, output logic swapped);
    logic [47:0] t;
    t = s.backup_server;
    swapped = (t != 48'd0);
    if (swapped) begin
      s.backup_server  = s.active_server;
      s.active_server  = t;
      s.current_server = t;
    end
  endfunction

  function automatic void take_candidates(inout ccf_state_t s, input logic [47:0] a,
                                          input logic [47:0] b, output logic changed);
    s.active_server  = a & EP_MASK;
    s.backup_server  = b & EP_MASK;
    changed          = (s.current_server != s.active_server);
    s.current_server = s.active_server;
  endfunction

  function automatic void connect_to_idle(inout ccf_state_t s, inout ccf_result_t r,
                                          input logic [31:0] dflt, input logic [15:0] maxs);
    s.idle_hold_ms = 32'(conn_time(s.attempt_count, maxs)) * MS_PER_SECOND;
    go_idle_hold(s, r, dflt);
    conn_cancel(s, r);
  endfunction

  function automatic void init_to_idle(inout ccf_state_t s, inout ccf_result_t r,
                                       input logic [31:0] dflt);
    go_idle_hold(s, r, dflt);
    conn_cancel(s, r);
  endfunction

  always_comb begin
    ccf_state_t  s;
    ccf_result_t r;
    logic [3:0]  act;
    logic [2:0]  st;
    logic        used;
    logic        flag;
    logic        had_conn;

    s        = cur;
    r        = '0;
    act      = item.action;
    st       = cur.fsm_state;
    used     = 1'b1;
    flag     = 1'b0;
    had_conn = 1'b0;

    if (act == ACT_START) begin
      s.idle_hold_ms = 32'd0;
    end
    if (act == ACT_IDLE_EXP) begin
      if (!s.idle_armed) begin
        act = ACT_IGNORED;
      end else begin
        s.idle_armed = 1'b0;
      end
    end else if (act == ACT_CONN_EXP) begin
      if (!s.connect_armed) begin
        act = ACT_IGNORED;
      end else begin
        s.connect_armed = 1'b0;
      end
    end

    if (act == ACT_DELETE) begin
      r.session_cmd = SESS_DELETE;
    end else if (act == ACT_STOP && st != ST_IDLE) begin
      had_conn = (st == ST_CONN) || (st == ST_INIT);
      release_all(s, r, default_idle_hold_ms);
      if (had_conn) begin
        conn_cancel(s, r);
      end
      s.fsm_state = ST_IDLE;
    end else if (act == ACT_SEND && st != ST_INIT && st != ST_EST) begin
      r.send_result = SEND_DROPPED;
    end else begin
      case (st)
        ST_DISC: begin
          if (act == ACT_CANDIDATES) begin
            s.active_server  = item.active_endpoint & EP_MASK;
            s.backup_server  = item.backup_endpoint & EP_MASK;
            s.current_server = s.active_server;
            r.link_status    = LINK_INIT;
            enter_connect(s, r, max_connect_seconds);
          end else begin
            used = 1'b0;
          end
        end
        ST_CONN: begin
          if (act == ACT_CONN_EXP || act == ACT_CONN_FAIL) begin
            swap_to_backup(s, flag);
            connect_to_idle(s, r, default_idle_hold_ms, max_connect_seconds);
          end else if (act == ACT_CLOSE) begin
            connect_to_idle(s, r, default_idle_hold_ms, max_connect_seconds);
          end else if (act == ACT_CONNECTED) begin
            r.link_status = LINK_INIT;
            conn_cancel(s, r);
            conn_start(s, r, conn_time(s.attempt_count, max_connect_seconds));
            r.session_cmd = SESS_INIT;
            s.fsm_state   = ST_INIT;
          end else if (act == ACT_CANDIDATES) begin
            take_candidates(s, item.active_endpoint, item.backup_endpoint, flag);
            if (flag) begin
              connect_to_idle(s, r, default_idle_hold_ms, max_connect_seconds);
            end
          end else begin
            used = 1'b0;
          end
        end
        ST_INIT: begin
          if (act == ACT_CONN_EXP) begin
            init_to_idle(s, r, default_idle_hold_ms);
          end else if (act == ACT_CLOSE) begin
            swap_to_backup(s, flag);
            init_to_idle(s, r, default_idle_hold_ms);
          end else if (act == ACT_RECV) begin
            if (!item.recv_ok) begin
              init_to_idle(s, r, default_idle_hold_ms);
            end else if (item.control_hint) begin
              conn_cancel(s, r);
              s.attempt_count = 8'd0;
              r.link_status   = LINK_UP;
              s.fsm_state     = ST_EST;
            end
          end else if (act == ACT_SEND) begin
            r.send_result = item.send_is_uve ? SEND_DROPPED : SEND_FORWARDED;
          end else if (act == ACT_CANDIDATES) begin
            take_candidates(s, item.active_endpoint, item.backup_endpoint, flag);
            if (flag) begin
              init_to_idle(s, r, default_idle_hold_ms);
            end
          end else begin
            used = 1'b0;
          end
        end
        ST_EST: begin
          if (act == ACT_CLOSE) begin
            swap_to_backup(s, flag);
            if (flag) begin
              r.link_status = LINK_INIT;
              release_all(s, r, default_idle_hold_ms);
              enter_connect(s, r, max_connect_seconds);
            end else begin
              go_idle_hold(s, r, default_idle_hold_ms);
            end
          end else if (act == ACT_RECV) begin
            if (!item.recv_ok) begin
              go_idle_hold(s, r, default_idle_hold_ms);
            end
          end else if (act == ACT_SEND) begin
            r.send_result = SEND_FORWARDED;
          end else if (act == ACT_CANDIDATES) begin
            take_candidates(s, item.active_endpoint, item.backup_endpoint, flag);
            if (flag) begin
              r.link_status = LINK_INIT;
              release_all(s, r, default_idle_hold_ms);
              enter_connect(s, r, max_connect_seconds);
            end
          end else begin
            used = 1'b0;
          end
        end
        default: begin
          if (act == ACT_START) begin
            idle_cancel(s, r);
            r.link_status = LINK_DOWN;
            s.fsm_state   = ST_DISC;
          end else if (act == ACT_STOP) begin
            idle_cancel(s, r);
          end else if (act == ACT_CANDIDATES) begin
            s.active_server = item.active_endpoint & EP_MASK;
            s.backup_server = item.backup_endpoint & EP_MASK;
          end else if (act == ACT_IDLE_EXP) begin
            s.current_server = s.active_server;
            r.link_status    = LINK_INIT;
            idle_cancel(s, r);
            enter_connect(s, r, max_connect_seconds);
          end else begin
            used = 1'b0;
          end
        end
      endcase
    end

    r.fsm_state_out = s.fsm_state;
    r.server_out    = s.current_server;
    r.consumed      = used;
    nxt             = s;
    res             = r;
  end

endmodule

`default_nettype wire

// File: tb/collector_connection_fsm_tb.sv
// Self-checking testbench for collector_connection_fsm: directed and randomized event
// sequences are driven through the valid/ready input; every result word is checked field by field.
// Depends on ccf_pkg and the collector_connection_fsm RTL only.
module collector_connection_fsm_tb;
  import ccf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  action = '0;
  logic [47:0] active_endpoint = '0;
  logic [47:0] backup_endpoint = '0;
  logic        recv_ok = 1'b0;
  logic        control_hint = 1'b0;
  logic        send_is_uve = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  fsm_state_out;
  logic [47:0] server_out;
  logic [1:0]  connect_timer_cmd;
  logic [15:0] connect_seconds;
  logic [1:0]  idle_timer_cmd;
  logic [31:0] idle_hold_out;
  logic [2:0]  session_cmd;
  logic [1:0]  send_result;
  logic [1:0]  link_status;
  logic        consumed;

  collector_connection_fsm i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .active_endpoint(active_endpoint), .backup_endpoint(backup_endpoint),
    .recv_ok(recv_ok), .control_hint(control_hint), .send_is_uve(send_is_uve),
    .out_valid(out_valid), .out_ready(out_ready),
    .fsm_state_out(fsm_state_out), .server_out(server_out),
    .connect_timer_cmd(connect_timer_cmd), .connect_seconds(connect_seconds),
    .idle_timer_cmd(idle_timer_cmd), .idle_hold_out(idle_hold_out),
    .session_cmd(session_cmd), .send_result(send_result),
    .link_status(link_status), .consumed(consumed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ccf_item_t   event_queue[$];
  ccf_result_t expected_reports[$];
  int          mismatches = 0;
  int          stall_asks = 0;

  // Connection state and register copies tracked alongside the block.
  ccf_state_t  conn = '0;
  logic [31:0] cfg_idle_hold = DEFAULT_IDLE_HOLD_RESET;
  logic [15:0] cfg_max_secs = MAX_CONNECT_RESET;
  ccf_result_t rep;

  function automatic logic [31:0] backoff_secs();
    logic [7:0]  b;
    logic [31:0] t;
    b = (conn.attempt_count < BACKOFF_CAP) ? conn.attempt_count : 8'(BACKOFF_CAP);
    t = (b == 8'd0) ? 32'd0 : (32'd1 << (b - 8'd1));
    return (t < {16'd0, cfg_max_secs}) ? t : {16'd0, cfg_max_secs};
  endfunction

  function automatic void start_conn(logic [31:0] secs);
    rep.connect_timer_cmd = TMR_START;
    rep.connect_seconds = secs[15:0];
    conn.connect_armed = 1'b1;
  endfunction

  function automatic void cancel_conn();
    rep.connect_timer_cmd = TMR_CANCEL;
    rep.connect_seconds = '0;
    conn.connect_armed = 1'b0;
  endfunction

  function automatic void cancel_idle();
    rep.idle_timer_cmd = TMR_CANCEL;
    rep.idle_hold_out = '0;
    conn.idle_armed = 1'b0;
  endfunction

  function automatic void release_session();
    if (conn.idle_hold_ms == 32'd0) conn.idle_hold_ms = cfg_idle_hold;
    cancel_idle();
    rep.session_cmd = SESS_RELEASE;
  endfunction

  function automatic void hold_in_idle();
    rep.link_status = LINK_DOWN;
    release_session();
    if (conn.idle_hold_ms != 32'd0) begin
      rep.idle_timer_cmd = TMR_START;
      rep.idle_hold_out = conn.idle_hold_ms;
      conn.idle_armed = 1'b1;
    end
    conn.fsm_state = ST_IDLE;
  endfunction

  function automatic void begin_connect();
    rep.session_cmd = (rep.session_cmd == SESS_RELEASE) ? SESS_REL_OPEN : SESS_OPEN;
    if (conn.attempt_count < ATTEMPT_MAX) conn.attempt_count = conn.attempt_count + 8'd1;
    start_conn(backoff_secs());
    conn.fsm_state = ST_CONN;
  endfunction

  function automatic logic fail_over();
    logic [47:0] t;
    if (conn.backup_server == '0) return 1'b0;
    t = conn.backup_server;
    conn.backup_server = conn.active_server;
    conn.active_server = t;
    conn.current_server = conn.active_server;
    return 1'b1;
  endfunction

  function automatic logic adopt_candidates(logic [47:0] a, logic [47:0] b);
    conn.active_server = a & EP_MASK;
    conn.backup_server = b & EP_MASK;
    if (conn.current_server != conn.active_server) begin
      conn.current_server = conn.active_server;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void backoff_to_idle();
    conn.idle_hold_ms = backoff_secs() * MS_PER_SECOND;
    hold_in_idle();
    cancel_conn();
  endfunction

  function automatic void drop_to_idle();
    hold_in_idle();
    cancel_conn();
  endfunction

  function automatic ccf_result_t apply_event(ccf_item_t ev);
    logic [3:0] act;
    logic [2:0] st;
    logic       used;
    act = ev.action;
    st = conn.fsm_state;
    used = 1'b1;
    rep = '0;
    if (act == ACT_START) conn.idle_hold_ms = '0;
    if (act == ACT_IDLE_EXP) begin
      if (!conn.idle_armed) act = ACT_IGNORED;
      else conn.idle_armed = 1'b0;
    end
    if (act == ACT_CONN_EXP) begin
      if (!conn.connect_armed) act = ACT_IGNORED;
      else conn.connect_armed = 1'b0;
    end
    if (act == ACT_DELETE) begin
      rep.session_cmd = SESS_DELETE;
    end else if (act == ACT_STOP && st != ST_IDLE) begin
      release_session();
      if (st == ST_CONN || st == ST_INIT) cancel_conn();
      conn.fsm_state = ST_IDLE;
    end else if (act == ACT_SEND && st != ST_INIT && st != ST_EST) begin
      rep.send_result = SEND_DROPPED;
    end else begin
      case (st)
        ST_DISC: begin
          if (act == ACT_CANDIDATES) begin
            conn.active_server = ev.active_endpoint & EP_MASK;
            conn.backup_server = ev.backup_endpoint & EP_MASK;
            conn.current_server = conn.active_server;
            rep.link_status = LINK_INIT;
            begin_connect();
          end else used = 1'b0;
        end
        ST_CONN: begin
          if (act == ACT_CONN_EXP || act == ACT_CONN_FAIL) begin
            void'(fail_over());
            backoff_to_idle();
          end else if (act == ACT_CLOSE) begin
            backoff_to_idle();
          end else if (act == ACT_CONNECTED) begin
            rep.link_status = LINK_INIT;
            cancel_conn();
            start_conn(backoff_secs());
            rep.session_cmd = SESS_INIT;
            conn.fsm_state = ST_INIT;
          end else if (act == ACT_CANDIDATES) begin
            if (adopt_candidates(ev.active_endpoint, ev.backup_endpoint)) backoff_to_idle();
          end else used = 1'b0;
        end
        ST_INIT: begin
          if (act == ACT_CONN_EXP) begin
            drop_to_idle();
          end else if (act == ACT_CLOSE) begin
            void'(fail_over());
            drop_to_idle();
          end else if (act == ACT_RECV) begin
            if (!ev.recv_ok) begin
              drop_to_idle();
            end else if (ev.control_hint) begin
              cancel_conn();
              conn.attempt_count = '0;
              rep.link_status = LINK_UP;
              conn.fsm_state = ST_EST;
            end
          end else if (act == ACT_SEND) begin
            rep.send_result = ev.send_is_uve ? SEND_DROPPED : SEND_FORWARDED;
          end else if (act == ACT_CANDIDATES) begin
            if (adopt_candidates(ev.active_endpoint, ev.backup_endpoint)) drop_to_idle();
          end else used = 1'b0;
        end
        ST_EST: begin
          if (act == ACT_CLOSE) begin
            if (fail_over()) begin
              rep.link_status = LINK_INIT;
              release_session();
              begin_connect();
            end else begin
              hold_in_idle();
            end
          end else if (act == ACT_RECV) begin
            if (!ev.recv_ok) hold_in_idle();
          end else if (act == ACT_SEND) begin
            rep.send_result = SEND_FORWARDED;
          end else if (act == ACT_CANDIDATES) begin
            if (adopt_candidates(ev.active_endpoint, ev.backup_endpoint)) begin
              rep.link_status = LINK_INIT;
              release_session();
              begin_connect();
            end
          end else used = 1'b0;
        end
        default: begin
          if (act == ACT_START) begin
            cancel_idle();
            rep.link_status = LINK_DOWN;
            conn.fsm_state = ST_DISC;
          end else if (act == ACT_STOP) begin
            cancel_idle();
          end else if (act == ACT_CANDIDATES) begin
            conn.active_server = ev.active_endpoint & EP_MASK;
            conn.backup_server = ev.backup_endpoint & EP_MASK;
          end else if (act == ACT_IDLE_EXP) begin
            conn.current_server = conn.active_server;
            rep.link_status = LINK_INIT;
            cancel_idle();
            begin_connect();
          end else used = 1'b0;
        end
      endcase
    end
    rep.fsm_state_out = conn.fsm_state;
    rep.server_out = conn.current_server;
    rep.consumed = used;
    return rep;
  endfunction

  // Sender: one word in flight, a random gap before each next word.
  ccf_item_t cur_event;
  int        send_wait = 0;
  int        send_calm = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(apply_event(cur_event));
        if (send_calm > 0) begin
          send_calm--;
          send_wait = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          send_calm = $urandom_range(10, 40);
          send_wait = 0;
        end else begin
          send_wait = $urandom_range(0, 8);
        end
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (event_queue.size() > 0) begin
          cur_event = event_queue.pop_front();
          action <= cur_event.action;
          active_endpoint <= cur_event.active_endpoint;
          backup_endpoint <= cur_event.backup_endpoint;
          recv_ok <= cur_event.recv_ok;
          control_hint <= cur_event.control_hint;
          send_is_uve <= cur_event.send_is_uve;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random hold-off after each word, plus long stalls on request.
  ccf_result_t want;
  int          recv_wait = 0;
  int          recv_calm = 0;
  int          stall_seen = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result word with none expected, actual state %0d", $time,
                   fsm_state_out);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("fsm_state_out", 64'(want.fsm_state_out), 64'(fsm_state_out));
          compare_field("server_out", 64'(want.server_out), 64'(server_out));
          compare_field("connect_timer_cmd", 64'(want.connect_timer_cmd),
                        64'(connect_timer_cmd));
          compare_field("connect_seconds", 64'(want.connect_seconds), 64'(connect_seconds));
          compare_field("idle_timer_cmd", 64'(want.idle_timer_cmd), 64'(idle_timer_cmd));
          compare_field("idle_hold_out", 64'(want.idle_hold_out), 64'(idle_hold_out));
          compare_field("session_cmd", 64'(want.session_cmd), 64'(session_cmd));
          compare_field("send_result", 64'(want.send_result), 64'(send_result));
          compare_field("link_status", 64'(want.link_status), 64'(link_status));
          compare_field("consumed", 64'(want.consumed), 64'(consumed));
        end
        if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          recv_calm = $urandom_range(10, 40);
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, 8);
        end
      end
      if (stall_asks != stall_seen) begin
        stall_seen = stall_asks;
        recv_wait = 60;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [47:0] pick_endpoint();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {48{1'b1}};
      default: return r[47:0];
    endcase
  endfunction

  function automatic ccf_item_t scrambled(logic [3:0] act);
    logic [127:0] bits;
    ccf_item_t    ev;
    bits = {$urandom, $urandom, $urandom, $urandom};
    ev = bits[$bits(ccf_item_t)-1:0];
    ev.action = act;
    ev.active_endpoint = pick_endpoint();
    ev.backup_endpoint = pick_endpoint();
    return ev;
  endfunction

  task automatic push_event(logic [3:0] act);
    event_queue.push_back(scrambled(act));
  endtask

  task automatic push_candidates(logic [47:0] a, logic [47:0] b);
    ccf_item_t ev;
    ev = scrambled(ACT_CANDIDATES);
    ev.active_endpoint = a;
    ev.backup_endpoint = b;
    event_queue.push_back(ev);
  endtask

  task automatic push_recv(logic ok, logic hint);
    ccf_item_t ev;
    ev = scrambled(ACT_RECV);
    ev.recv_ok = ok;
    ev.control_hint = hint;
    event_queue.push_back(ev);
  endtask

  task automatic push_send(logic uve);
    ccf_item_t ev;
    ev = scrambled(ACT_SEND);
    ev.send_is_uve = uve;
    event_queue.push_back(ev);
  endtask

  task automatic queue_directed();
    push_event(ACT_IDLE_EXP);
    push_event(ACT_CONN_EXP);
    push_send(1'b0);
    push_recv(1'b1, 1'b1);
    push_event(ACT_STOP);
    push_candidates({48{1'b1}}, '0);
    push_event(ACT_START);
    push_candidates({48{1'b1}}, 48'd1);
    push_event(ACT_CONN_EXP);
    push_event(ACT_IDLE_EXP);
    push_event(ACT_CONN_FAIL);
    push_event(ACT_IDLE_EXP);
    push_event(ACT_CONNECTED);
    push_send(1'b1);
    push_send(1'b0);
    push_recv(1'b1, 1'b0);
    push_recv(1'b1, 1'b1);
    push_send(1'b1);
    push_candidates({48{1'b1}}, 48'd1);
    push_event(ACT_CLOSE);
    push_event(ACT_CONNECTED);
    push_recv(1'b0, 1'b1);
    push_event(ACT_DELETE + 4'd1);
    push_event(ACT_IGNORED);
    push_event(ACT_DELETE);
    push_event(ACT_START);
  endtask

  // Connect attempts with retries from a clean idle state towards established, maybe back.
  task automatic queue_session();
    logic [47:0] a;
    logic [47:0] b;
    a = pick_endpoint();
    b = pick_endpoint();
    push_event(ACT_STOP);
    push_event(ACT_START);
    push_candidates(a, b);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: push_event(ACT_CONN_FAIL);
        1: push_event(ACT_CONN_EXP);
        2: push_event(ACT_CLOSE);
        default: push_candidates(pick_endpoint(), pick_endpoint());
      endcase
      push_event(ACT_IDLE_EXP);
    end
    push_event(ACT_CONNECTED);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: push_send(1'($urandom_range(0, 1)));
        1: push_recv(1'b1, 1'b0);
        default: push_candidates(a, b);
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: push_recv(1'b0, 1'($urandom_range(0, 1)));
        1: push_event(ACT_CLOSE);
        2: push_event(ACT_CONN_EXP);
        default: push_candidates(pick_endpoint(), pick_endpoint());
      endcase
      push_event(ACT_IDLE_EXP);
    end
    push_recv(1'b1, 1'b1);
    repeat ($urandom_range(2, 10)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: push_send(1'($urandom_range(0, 1)));
        6, 7, 8, 9, 10: push_recv(1'b1, 1'($urandom_range(0, 1)));
        11, 12: push_candidates(a, b);
        13: push_candidates(pick_endpoint(), pick_endpoint());
        14: push_event(ACT_CLOSE);
        15: push_recv(1'b0, 1'($urandom_range(0, 1)));
        default: push_event(4'($urandom_range(0, 15)));
      endcase
    end
    case ($urandom_range(0, 3))
      0: push_event(ACT_STOP);
      1: push_event(ACT_CLOSE);
      2: push_event(ACT_DELETE);
      default: ;
    endcase
  endtask

  task automatic queue_random(int n);
    int base;
    @(negedge clk);
    base = event_queue.size();
    while (event_queue.size() < base + n) begin
      if ($urandom_range(0, 9) == 0) push_event(4'($urandom_range(0, 15)));
      else queue_session();
    end
  endtask

  task automatic finish_phase();
    @(negedge clk);
    stall_asks <= stall_asks + 1;
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_DEFAULT_IDLE_HOLD) cfg_idle_hold = value;
    else cfg_max_secs = value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    queue_random(300);
    finish_phase();
    write_register(REG_DEFAULT_IDLE_HOLD, 32'd0);
    write_register(REG_MAX_CONNECT, 32'd0);
    queue_random(330);
    finish_phase();
    write_register(REG_DEFAULT_IDLE_HOLD, 32'hFFFF_FFFF);
    write_register(REG_MAX_CONNECT, {16'($urandom), 16'hFFFF});
    queue_random(330);
    finish_phase();
    write_register(REG_DEFAULT_IDLE_HOLD, $urandom);
    write_register(REG_MAX_CONNECT, $urandom_range(1, 8));
    queue_random(330);
    finish_phase();
    write_register(REG_DEFAULT_IDLE_HOLD, 32'd1);
    write_register(REG_MAX_CONNECT, 32'd1);
    queue_random(330);
    finish_phase();
    if (mismatches == 0) begin
      $display("collector_connection_fsm_tb: PASS");
    end else begin
      $display("collector_connection_fsm_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("collector_connection_fsm_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/ccf_pkg.sv
design/ccf_step.sv
design/collector_connection_fsm.sv
tb/collector_connection_fsm_tb.sv
